// ----- rtl/core/pwls_pkg.sv -----
// Shared types and constants for the piecewise-linear sensor scaling block.
package pwls_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 128;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = IDX_W + 1;

    // Field widths
    localparam int REQ_W   = 1;
    localparam int ENTRY_W = 7;
    localparam int RAW_W   = 12;
    localparam int VAL_W   = 16;
    localparam int SEG_W   = 7;

    // Comparison width wide enough for segment index and segment count
    localparam int CMP_W = ((CNT_W > SEG_W) ? CNT_W : SEG_W) + 1;

    // Arithmetic widths: value difference, product and divider steps
    localparam int DY_W      = VAL_W + 1;
    localparam int PROD_W    = RAW_W + DY_W;
    localparam int DIV_STEPS = PROD_W;
    localparam int DCNT_W    = $clog2(DIV_STEPS);
    localparam int SUM_W     = VAL_W + 2;

    // Breakpoint storage word: scaled value above raw count
    localparam int BP_W = RAW_W + VAL_W;

    // Reset value of the segment count register
    localparam logic [SEG_W-1:0] SEG_COUNT_RESET = SEG_W'(100);

    // Result for a sample outside every segment
    localparam logic signed [VAL_W-1:0] MISS_VALUE = -VAL_W'(1);

    // Request codes
    localparam logic [REQ_W-1:0] REQ_LOAD    = 1'b0;
    localparam logic [REQ_W-1:0] REQ_CONVERT = 1'b1;

    typedef struct packed {
        logic [REQ_W-1:0]          req_type;
        logic [ENTRY_W-1:0]        entry_index;
        logic [RAW_W-1:0]          entry_raw;
        logic signed [VAL_W-1:0]   entry_scaled;
        logic [RAW_W-1:0]          raw_sample;
    } t_in_beat;

    typedef struct packed {
        logic signed [VAL_W-1:0] scaled_value;
        logic                    in_range;
    } t_out_beat;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH0,
        ST_FETCH1,
        ST_SCAN,
        ST_MUL,
        ST_DIV,
        ST_FIN,
        ST_DONE
    } t_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_write;
        logic start;
        logic fetch;
        logic prime;
        logic step;
        logic capture;
        logic mul;
        logic div_step;
        logic fin;
        logic set_miss;
        logic emit;
    } t_ctrl_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic match;
        logic stop;
        logic div_done;
        logic out_free;
    } t_ctrl_sts;

endpackage

// ----- rtl/core/piecewise_linear_sensor_scale.sv -----
// A load beat is written to the table in its accept cycle and gives no result.
// A convert searches the segments in order, then multiplies, runs a 29-step serial
// divide and the final add; a miss skips the arithmetic. The input stalls until the
// result has moved to the output register, so one convert is in flight at a time.
// Reset (synchronous, active low) idles the controller, empties the output register and
// sets the segment count to 100; the breakpoint table is not cleared.
module piecewise_linear_sensor_scale (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  pwls_pkg::t_in_beat         i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output pwls_pkg::t_out_beat        o_out_data,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [pwls_pkg::SEG_W-1:0] i_cfg_data
);

    pwls_pkg::t_ctrl_cmd cmd;
    pwls_pkg::t_ctrl_sts sts;

    // Configuration writes are always taken
    assign o_cfg_ready = 1'b1;

    pwls_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .i_req_type(i_in_data.req_type),
        .i_sts     (sts),
        .o_cmd     (cmd),
        .o_in_stall(o_in_stall)
    );

    pwls_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_out_stall(i_out_stall),
        .o_out_valid(o_out_valid),
        .o_out_data (o_out_data)
    );

endmodule

// ----- rtl/core/pwls_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module pwls_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/pwls_ctrl.sv -----
// Controller state machine for breakpoint loads and sample conversion.
module pwls_ctrl (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  logic [pwls_pkg::REQ_W-1:0] i_req_type,
    input  pwls_pkg::t_ctrl_sts      i_sts,
    output pwls_pkg::t_ctrl_cmd      o_cmd,
    output logic                     o_in_stall
);

    pwls_pkg::t_state r_state;
    pwls_pkg::t_state n_state;
    logic             in_take;

    assign in_take = i_in_valid && (r_state == pwls_pkg::ST_IDLE);

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pwls_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pwls_pkg::ST_IDLE: begin
                if (in_take && (i_req_type == pwls_pkg::REQ_CONVERT)) begin
                    n_state = pwls_pkg::ST_FETCH0;
                end
            end
            pwls_pkg::ST_FETCH0: n_state = pwls_pkg::ST_FETCH1;
            pwls_pkg::ST_FETCH1: n_state = pwls_pkg::ST_SCAN;
            pwls_pkg::ST_SCAN: begin
                if (i_sts.match) begin
                    n_state = pwls_pkg::ST_MUL;
                end else if (i_sts.stop) begin
                    n_state = pwls_pkg::ST_DONE;
                end
            end
            pwls_pkg::ST_MUL: n_state = pwls_pkg::ST_DIV;
            pwls_pkg::ST_DIV: begin
                if (i_sts.div_done) begin
                    n_state = pwls_pkg::ST_FIN;
                end
            end
            pwls_pkg::ST_FIN: n_state = pwls_pkg::ST_DONE;
            pwls_pkg::ST_DONE: begin
                if (i_sts.out_free) begin
                    n_state = pwls_pkg::ST_IDLE;
                end
            end
            default: n_state = pwls_pkg::ST_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        o_cmd = '0;
        case (r_state)
            pwls_pkg::ST_IDLE: begin
                o_cmd.load_write = in_take && (i_req_type == pwls_pkg::REQ_LOAD);
                o_cmd.start      = in_take && (i_req_type == pwls_pkg::REQ_CONVERT);
            end
            pwls_pkg::ST_FETCH0: o_cmd.fetch = 1'b1;
            pwls_pkg::ST_FETCH1: o_cmd.prime = 1'b1;
            pwls_pkg::ST_SCAN: begin
                o_cmd.capture  = i_sts.match;
                o_cmd.set_miss = !i_sts.match && i_sts.stop;
                o_cmd.step     = !i_sts.match && !i_sts.stop;
            end
            pwls_pkg::ST_MUL: o_cmd.mul = 1'b1;
            pwls_pkg::ST_DIV: o_cmd.div_step = 1'b1;
            pwls_pkg::ST_FIN: o_cmd.fin = 1'b1;
            pwls_pkg::ST_DONE: o_cmd.emit = i_sts.out_free;
            default: o_cmd = '0;
        endcase
    end

    assign o_in_stall = (r_state != pwls_pkg::ST_IDLE);

endmodule

// ----- rtl/core/pwls_datapath.sv -----
// Datapath: breakpoint table, segment search, multiplier, serial divider, final add and output register.
module pwls_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pwls_pkg::t_in_beat            i_in_data,
    input  logic                          i_cfg_we,
    input  logic [pwls_pkg::SEG_W-1:0]    i_cfg_data,
    input  pwls_pkg::t_ctrl_cmd           i_cmd,
    output pwls_pkg::t_ctrl_sts           o_sts,
    input  logic                          i_out_stall,
    output logic                          o_out_valid,
    output pwls_pkg::t_out_beat           o_out_data
);

    localparam int IDX_W  = pwls_pkg::IDX_W;
    localparam int CNT_W  = pwls_pkg::CNT_W;
    localparam int CMP_W  = pwls_pkg::CMP_W;
    localparam int RAW_W  = pwls_pkg::RAW_W;
    localparam int VAL_W  = pwls_pkg::VAL_W;
    localparam int DY_W   = pwls_pkg::DY_W;
    localparam int PROD_W = pwls_pkg::PROD_W;
    localparam int DCNT_W = pwls_pkg::DCNT_W;
    localparam int SUM_W  = pwls_pkg::SUM_W;
    localparam int BP_W   = pwls_pkg::BP_W;
    localparam int EXT_W  = (pwls_pkg::ENTRY_W > IDX_W ? pwls_pkg::ENTRY_W : IDX_W) + 1;

    // Configuration register
    logic [pwls_pkg::SEG_W-1:0] r_seg_count;

    // Search registers
    logic [RAW_W-1:0]        r_sample;
    logic [CNT_W-1:0]        r_addr;
    logic [IDX_W-1:0]        r_seg;
    logic [RAW_W-1:0]        r_x0;
    logic signed [VAL_W-1:0] r_y0;

    // Arithmetic registers
    logic [RAW_W-1:0]        r_dx;
    logic [RAW_W-1:0]        r_den;
    logic signed [DY_W-1:0]  r_dy;
    logic                    r_neg;
    logic [PROD_W-1:0]       r_quo;
    logic [RAW_W-1:0]        r_rem;
    logic [DCNT_W-1:0]       r_div_cnt;

    // Result and output registers
    pwls_pkg::t_out_beat r_res;
    pwls_pkg::t_out_beat r_out;
    logic                r_out_valid;

    // Table memory signals
    logic                    ram_we;
    logic [BP_W-1:0]         ram_wdata;
    logic [BP_W-1:0]         ram_rdata;
    logic [RAW_W-1:0]        x1;
    logic signed [VAL_W-1:0] y1;

    // Search compare signals
    logic [CMP_W-1:0] seg_ext;
    logic [CMP_W-1:0] cnt_ext;
    logic             seg_ok;
    logic             seg_last;

    // Multiply and divide signals
    logic [DY_W-1:0]   dy_mag;
    logic [PROD_W-1:0] prod;
    logic [RAW_W:0]    rem_shift;
    logic              quo_bit;
    logic [RAW_W:0]    rem_diff;
    logic signed [SUM_W-1:0] q_signed;
    logic signed [SUM_W-1:0] sum;

    // Breakpoint table: raw count in the low bits, scaled value above
    assign ram_we = i_cmd.load_write &&
                    (EXT_W'(i_in_data.entry_index) < EXT_W'(pwls_pkg::TABLE_DEPTH));
    assign ram_wdata = {i_in_data.entry_scaled, i_in_data.entry_raw};

    pwls_ram #(
        .WIDTH(BP_W),
        .DEPTH(pwls_pkg::TABLE_DEPTH)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(i_in_data.entry_index[IDX_W-1:0]),
        .i_wdata(ram_wdata),
        .i_raddr(r_addr[IDX_W-1:0]),
        .o_rdata(ram_rdata)
    );

    assign x1 = ram_rdata[RAW_W-1:0];
    assign y1 = ram_rdata[BP_W-1:RAW_W];

    // Segment tests: inside count, last searchable segment, sample hit
    assign seg_ext  = CMP_W'(r_seg);
    assign cnt_ext  = CMP_W'(r_seg_count);
    assign seg_ok   = seg_ext < cnt_ext;
    assign seg_last = ((seg_ext + CMP_W'(1)) >= cnt_ext) ||
                      ((seg_ext + CMP_W'(2)) >= CMP_W'(pwls_pkg::TABLE_DEPTH));

    assign o_sts.match    = seg_ok && (r_sample >= r_x0) && (r_sample < x1);
    assign o_sts.stop     = !seg_ok || seg_last;
    assign o_sts.div_done = (r_div_cnt == DCNT_W'(pwls_pkg::DIV_STEPS - 1));
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    // Magnitude product of sample offset and value rise
    assign dy_mag = r_dy[DY_W-1] ? DY_W'(-r_dy) : DY_W'(r_dy);
    assign prod   = PROD_W'(r_dx) * PROD_W'(dy_mag);

    // One restoring divide step
    assign rem_shift = {r_rem, r_quo[PROD_W-1]};
    assign rem_diff  = rem_shift - {1'b0, r_den};
    assign quo_bit   = (rem_shift >= {1'b0, r_den});

    // Apply sign to quotient and add segment base
    assign q_signed = r_neg ? -SUM_W'(r_quo[VAL_W:0]) : SUM_W'(r_quo[VAL_W:0]);
    assign sum      = SUM_W'(r_y0) + q_signed;

    // Hold segment count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_count <= pwls_pkg::SEG_COUNT_RESET;
        end else if (i_cfg_we) begin
            r_seg_count <= i_cfg_data;
        end
    end

    // Advance search address and segment
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_sample <= i_in_data.raw_sample;
            r_addr   <= '0;
        end
        if (i_cmd.fetch) begin
            r_addr <= r_addr + CNT_W'(1);
        end
        if (i_cmd.prime) begin
            r_x0   <= x1;
            r_y0   <= y1;
            r_seg  <= '0;
            r_addr <= r_addr + CNT_W'(1);
        end
        if (i_cmd.step) begin
            r_x0   <= x1;
            r_y0   <= y1;
            r_seg  <= r_seg + IDX_W'(1);
            r_addr <= r_addr + CNT_W'(1);
        end
    end

    // Capture segment deltas, multiply, divide
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_dx  <= r_sample - r_x0;
            r_den <= x1 - r_x0;
            r_dy  <= DY_W'(y1) - DY_W'(r_y0);
        end
        if (i_cmd.mul) begin
            r_neg     <= r_dy[DY_W-1];
            r_quo     <= prod;
            r_rem     <= '0;
            r_div_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem     <= quo_bit ? rem_diff[RAW_W-1:0] : rem_shift[RAW_W-1:0];
            r_quo     <= {r_quo[PROD_W-2:0], quo_bit};
            r_div_cnt <= r_div_cnt + DCNT_W'(1);
        end
    end

    // Form result
    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            r_res.scaled_value <= sum[VAL_W-1:0];
            r_res.in_range     <= 1'b1;
        end
        if (i_cmd.set_miss) begin
            r_res.scaled_value <= pwls_pkg::MISS_VALUE;
            r_res.in_range     <= 1'b0;
        end
    end

    // Output register: load on emit, drop when the beat is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ----- bench/piecewise_linear_sensor_scale_checker.sv -----
// Checker for the sensor scaling block: tracks the breakpoint table, predicts and compares results.
module piecewise_linear_sensor_scale_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_stall,
    input  pwls_pkg::t_in_beat         i_in_data,
    input  logic                       i_out_valid,
    input  logic                       i_out_stall,
    input  pwls_pkg::t_out_beat        i_out_data,
    input  logic                       i_cfg_valid,
    input  logic                       i_cfg_ready,
    input  logic [pwls_pkg::SEG_W-1:0] i_cfg_data,
    output int                         o_fail_count,
    output int                         o_pending
);
    import pwls_pkg::*;

    // Shadow copy of the breakpoint table and the segment count
    logic [RAW_W-1:0]        lut_raw    [TABLE_DEPTH];
    logic signed [VAL_W-1:0] lut_scaled [TABLE_DEPTH];
    logic [SEG_W-1:0]        seg_limit;

    t_out_beat expected_scaled [$];
    t_out_beat want;
    int        fail_total = 0;

    assign o_fail_count = fail_total;

    // Print one line per mismatch and count it
    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        fail_total++;
    endtask

    // Search segments in order and interpolate, quotient truncated toward zero
    function automatic t_out_beat linearize_sample(input logic [RAW_W-1:0] sample);
        t_out_beat res;
        int        k;
        int        offset;
        int        rise;
        int        run;
        longint    quo;
        res.scaled_value = MISS_VALUE;
        res.in_range     = 1'b0;
        for (k = 0; k < int'(seg_limit) && k + 1 < TABLE_DEPTH; k++) begin
            if (sample >= lut_raw[k] && sample < lut_raw[k+1]) begin
                offset = int'(sample) - int'(lut_raw[k]);
                rise   = int'(lut_scaled[k+1]) - int'(lut_scaled[k]);
                run    = int'(lut_raw[k+1]) - int'(lut_raw[k]);
                quo    = (longint'(offset) * longint'(rise)) / longint'(run);
                res.scaled_value = VAL_W'(int'(lut_scaled[k]) + int'(quo));
                res.in_range     = 1'b1;
                return res;
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_scaled.delete();
            seg_limit = SEG_COUNT_RESET;
            o_pending <= 0;
        end else begin
            // Retire a result beat against the oldest expectation
            if (i_out_valid && !i_out_stall) begin
                if (expected_scaled.size() == 0) begin
                    report_mismatch($sformatf("result %0d/%0b with nothing pending",
                        $signed(i_out_data.scaled_value), i_out_data.in_range));
                end else begin
                    want = expected_scaled.pop_front();
                    if (i_out_data.scaled_value !== want.scaled_value) begin
                        report_mismatch($sformatf("scaled_value got %0d expected %0d",
                            $signed(i_out_data.scaled_value), $signed(want.scaled_value)));
                    end
                    if (i_out_data.in_range !== want.in_range) begin
                        report_mismatch($sformatf("in_range got %0b expected %0b",
                            i_out_data.in_range, want.in_range));
                    end
                end
            end

            // Track segment count writes
            if (i_cfg_valid && i_cfg_ready) begin
                seg_limit = i_cfg_data;
            end

            // Apply a load beat or predict a convert beat
            if (i_in_valid && !i_in_stall) begin
                if (i_in_data.req_type == REQ_LOAD) begin
                    if (int'(i_in_data.entry_index) < TABLE_DEPTH) begin
                        lut_raw[i_in_data.entry_index]    = i_in_data.entry_raw;
                        lut_scaled[i_in_data.entry_index] = i_in_data.entry_scaled;
                    end
                end else begin
                    expected_scaled.push_back(linearize_sample(i_in_data.raw_sample));
                end
            end

            o_pending <= expected_scaled.size();
        end
    end

endmodule

// ----- bench/piecewise_linear_sensor_scale_tb.sv -----
// Testbench top for the sensor scaling block: clock, reset, stimulus and verdict.
module piecewise_linear_sensor_scale_tb;
    import pwls_pkg::*;

    localparam int RANDOM_BEATS   = 1400;
    localparam int QUIET_AFTER    = 1150;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int TAIL_CYCLES    = 200;
    localparam int SETTLE_CYCLES  = 4;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             in_stall;
    t_in_beat         in_data   = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    t_out_beat        out_data;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [SEG_W-1:0] cfg_data  = '0;

    int fail_count;
    int pending;
    int beats_sent  = 0;
    int idle_cycles = 0;
    int stall_left  = 0;
    bit gaps_on     = 1'b1;
    bit stalls_on   = 1'b1;
    int plan_raw [TABLE_DEPTH];

    always #2 clk = ~clk;

    piecewise_linear_sensor_scale dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    piecewise_linear_sensor_scale_checker scale_chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Stall the result side in random bursts while stalls are on
    always @(posedge clk) begin
        if (!stalls_on) begin
            stall_left <= 0;
            out_stall  <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end else if ($urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(0, 17);
            out_stall  <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // End the run when no beat moves for too long
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
                || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offer one input beat, with an optional gap, and hold it until accepted
    task automatic push_beat(input t_in_beat beat);
        int gap;
        if (gaps_on && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 18);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        do @(posedge clk); while (in_stall);
        beats_sent++;
    endtask

    task automatic load_breakpoint(input int idx, input int raw, input int scaled);
        t_in_beat beat;
        beat.req_type     = REQ_LOAD;
        beat.entry_index  = ENTRY_W'(idx);
        beat.entry_raw    = RAW_W'(raw);
        beat.entry_scaled = VAL_W'(scaled);
        beat.raw_sample   = RAW_W'($urandom);
        plan_raw[idx]     = raw;
        push_beat(beat);
    endtask

    task automatic convert_sample(input int sample);
        t_in_beat beat;
        beat.req_type     = REQ_CONVERT;
        beat.entry_index  = ENTRY_W'($urandom);
        beat.entry_raw    = RAW_W'($urandom);
        beat.entry_scaled = VAL_W'($urandom);
        beat.raw_sample   = RAW_W'(sample);
        push_beat(beat);
    endtask

    // Drop valid and wait until every expected result has been taken
    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // Write the segment count while the block is idle
    task automatic write_seg_count(input int count);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= SEG_W'(count);
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int seg;
        int top_idx;
        int stride;
        int x;
        int y;
        int conv_n;
        int lo;
        int hi;
        int pick;
        int sample;
        int k;
        int j;
        int phase;
        int random_start;
        bit monotonic;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes, a steep edge, a falling segment, misses
        write_seg_count(3);
        load_breakpoint(0, 0, -32768);
        load_breakpoint(1, 2048, 32767);
        load_breakpoint(2, 2049, 0);
        load_breakpoint(3, 4095, -7);
        load_breakpoint(127, 4095, 32767);
        convert_sample(0);
        convert_sample(1);
        convert_sample(2047);
        convert_sample(2048);
        convert_sample(2049);
        convert_sample(3000);
        convert_sample(4095);
        // Zero segments: always a miss
        write_seg_count(0);
        convert_sample(100);
        // One segment: miss above the first span, hit inside it
        write_seg_count(1);
        convert_sample(3000);
        convert_sample(5);

        // Random phases: new segment count, fresh table, then converts
        random_start = beats_sent;
        phase = 0;
        while (beats_sent - random_start < RANDOM_BEATS) begin
            if (beats_sent - random_start > QUIET_AFTER) begin
                gaps_on = 1'b0;
                stalls_on <= 1'b0;
            end else begin
                gaps_on = ($urandom_range(0, 3) != 0);
                stalls_on <= ($urandom_range(0, 3) != 0);
            end

            pick = $urandom_range(0, 19);
            if (phase == 0 || pick == 0) begin
                seg = 127;
            end else if (phase == 1 || pick == 1) begin
                seg = 1;
            end else if (pick == 2) begin
                seg = 0;
            end else if (pick < 6) begin
                seg = $urandom_range(17, 126);
            end else begin
                seg = $urandom_range(2, 16);
            end
            phase++;
            write_seg_count(seg);

            // Load entries 0 .. seg+1 (at most 127), mostly rising raw counts
            top_idx   = (seg + 1 > TABLE_DEPTH - 1) ? TABLE_DEPTH - 1 : seg + 1;
            monotonic = ($urandom_range(0, 4) != 0);
            stride    = 4096 / (top_idx + 1);
            x         = $urandom_range(0, stride);
            for (k = 0; k <= top_idx; k++) begin
                if (!monotonic) begin
                    x = $urandom_range(0, 4095);
                end
                if ($urandom_range(0, 3) == 0) begin
                    y = $urandom_range(0, 200) - 100;
                end else begin
                    y = $urandom_range(0, 65535) - 32768;
                end
                load_breakpoint(k, x, y);
                if (monotonic) begin
                    x = x + $urandom_range(1, 2 * stride - 1);
                    if (x > 4095) begin
                        x = 4095;
                    end
                end
            end

            // Convert samples, with stray loads and an occasional full drain
            lo     = plan_raw[0];
            hi     = plan_raw[seg];
            conv_n = $urandom_range(20, 60);
            for (j = 0; j < conv_n; j++) begin
                pick = $urandom_range(0, 19);
                if (pick == 0) begin
                    load_breakpoint($urandom_range(0, TABLE_DEPTH - 1),
                        $urandom_range(0, 4095), $urandom_range(0, 65535) - 32768);
                end else if (pick == 1) begin
                    wait_drained();
                end else begin
                    pick = $urandom_range(0, 9);
                    if (pick < 6 && lo <= hi) begin
                        sample = $urandom_range(lo, hi);
                    end else if (pick == 6) begin
                        sample = plan_raw[$urandom_range(0, seg)];
                    end else if (pick == 7) begin
                        sample = plan_raw[$urandom_range(0, seg)] - 1;
                        if (sample < 0) begin
                            sample = 0;
                        end
                    end else begin
                        sample = $urandom_range(0, 4095);
                    end
                    convert_sample(sample);
                end
            end
        end

        // Drain, then watch for stray results
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/pwls_pkg.sv
rtl/core/pwls_ram.sv
rtl/core/pwls_ctrl.sv
rtl/core/pwls_datapath.sv
rtl/core/piecewise_linear_sensor_scale.sv
bench/piecewise_linear_sensor_scale_checker.sv
bench/piecewise_linear_sensor_scale_tb.sv
